// File: design/phlm_pkg.sv
// ----------------------------------------------------------------------------
// phlm_pkg: shared types and constants of the peak-hold level meter
// Field widths, scaling constants, the segment ladder and the divider sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package phlm_pkg;

   // number of deviation segments in use (1..16)
   localparam int SEGMENT_COUNT = 16;

   // item field widths
   localparam int DEV_W   = 16;
   localparam int LEVEL_W = 8;
   localparam int KHZ_W   = 14;
   localparam int SEG_W   = 5;
   localparam int BAR_W   = 7;
   localparam int TICK_W  = 8;
   localparam int FS_W    = 8;
   localparam int Q_W     = 10;   // bar ratio below full scale is < 1000

   // shared multiplier operand and product widths
   localparam int MUL_A_W = 27;
   localparam int MUL_B_W = 28;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // shared divider: dividend (level * 1000) and divisor (full scale) widths
   localparam int DIV_N_W   = 18;
   localparam int DIV_D_W   = FS_W;
   localparam int DIV_CNT_W = $clog2(DIV_N_W);

   // kHz scaling: dev * 148 / 1000 == (dev * KHZ_RECIP) >> KHZ_SHIFT for any
   // 16-bit dev; KHZ_RECIP = ceil(148 * 2^24 / 1000)
   localparam logic [MUL_B_W-1:0] KHZ_RECIP  = MUL_B_W'(2483028);
   localparam int                 KHZ_SHIFT  = 24;
   // squared length: p / 1000000 == (p * LEN_RECIP) >> LEN_SHIFT for any
   // 27-bit p; LEN_RECIP = ceil(2^47 / 1000000)
   localparam logic [MUL_B_W-1:0] LEN_RECIP  = MUL_B_W'(140737489);
   localparam int                 LEN_SHIFT  = 47;
   localparam logic [MUL_B_W-1:0] RATIO_MULT = MUL_B_W'(1000);
   localparam logic [BAR_W-1:0]   BAR_MIN_LEN = BAR_W'(2);

   // configuration register indexes and reset values
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TICKS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BAR_MAX      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SNR_FS       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STRENGTH_FS  = 2'd3;
   localparam int CSR_DATA_W = 8;

   localparam logic [TICK_W-1:0] HOLD_TICKS_RST  = 8'd15;
   localparam logic [BAR_W-1:0]  BAR_MAX_RST     = 7'd40;
   localparam logic [FS_W-1:0]   SNR_FS_RST      = 8'd31;
   localparam logic [FS_W-1:0]   STRENGTH_FS_RST = 8'd100;

   // ascending kHz thresholds of the segments
   localparam logic [KHZ_W-1:0] LADDER [16] = '{
      14'd1,   14'd10,  14'd20,  14'd35,  14'd50,  14'd70,  14'd95,  14'd125,
      14'd160, 14'd205, 14'd260, 14'd330, 14'd420, 14'd540, 14'd700, 14'd950
   };

   // segment state handed from the peak tracker to the top level
   typedef struct packed {
      logic [SEG_W-1:0] lit;
      logic [SEG_W-1:0] peak;
   } peak_status_type;

endpackage

`default_nettype wire

// File: design/phlm_div.sv
// ----------------------------------------------------------------------------
// phlm_div: shared restoring divider
// Unsigned quotient, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module phlm_div
   import phlm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [DIV_N_W-1:0] dividend,
   input  wire logic [DIV_D_W-1:0] divisor,
   output logic                    done,
   output logic [DIV_N_W-1:0]      quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_N_W-1:0]   quo_ff, quo_in;

   logic [DIV_D_W:0]     shifted;
   logic [DIV_D_W+1:0]   diff;
   logic                 neg;

   // one trial subtraction per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_N_W-1]};
      diff    = {1'b0, shifted} - {2'b00, divisor};
      neg     = diff[DIV_D_W+1];

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_N_W - 1);
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = neg ? shifted[DIV_D_W-1:0] : diff[DIV_D_W-1:0];
         quo_in = {quo_ff[DIV_N_W-2:0], ~neg};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// File: design/phlm_peak.sv
// ----------------------------------------------------------------------------
// phlm_peak: segment quantizer and peak-hold tracker
// Counts ladder rungs reached by the kHz value and runs hold-then-decay.
// ----------------------------------------------------------------------------
`default_nettype none

module phlm_peak
   import phlm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              update,
   input  wire logic [KHZ_W-1:0]  khz,
   input  wire logic [TICK_W-1:0] hold_ticks,
   output peak_status_type        status
);

   logic [SEG_W-1:0]  segs;
   logic [SEG_W-1:0]  peak_ff, peak_in;
   logic [TICK_W-1:0] timer_ff, timer_in;
   logic [SEG_W-1:0]  lit_ff, lit_in;

   // ladder is ascending, so the rungs reached are the rungs at or below khz
   always_comb begin
      segs = '0;
      for (int i = 0; i < SEGMENT_COUNT; i++) begin
         segs = segs + {{(SEG_W-1){1'b0}}, (khz >= LADDER[i])};
      end
   end

   // hold-then-decay
   always_comb begin
      peak_in  = peak_ff;
      timer_in = timer_ff;
      lit_in   = lit_ff;
      if (update) begin
         lit_in = segs;
         priority if (segs > peak_ff) begin
            peak_in  = segs;
            timer_in = hold_ticks;
         end else if (timer_ff != '0) begin
            timer_in = timer_ff - 1'b1;
         end else if (peak_ff != '0) begin
            peak_in = peak_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff  <= '0;
         timer_ff <= '0;
      end else begin
         peak_ff  <= peak_in;
         timer_ff <= timer_in;
      end
      lit_ff <= lit_in;
   end

   assign status.lit  = lit_ff;
   assign status.peak = peak_ff;

endmodule

`default_nettype wire

// File: design/peak_hold_level_meter.sv
// ----------------------------------------------------------------------------
// peak_hold_level_meter: deviation meter with peak hold and two level bars
// Sequencer around one shared multiplier and one shared iterative divider.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one meter update per item (deviation, strength, SNR readings).
//   rsp_*  : one result item per update: kHz value, lit segments, held peak,
//            SNR bar length and strength bar length.
//   csr_*  : register writes (hold ticks, bar maximum, SNR and strength full
//            scale); always ready, to be written only while the block is idle.
// Timing:
//   An update spends most of its time from acceptance to rsp_tvalid in two
//   passes through the 18-step restoring divider, one per bar ratio; kHz
//   scaling and the squared length use reciprocal multiplies on the shared
//   multiplier. One update is in work at a time and req_tready is high only
//   while the sequencer is idle, so the next update is taken only once the
//   last one has passed the output step.
// Reset:
//   Registers return to their default values, the peak and hold timer clear,
//   and no result is pending.
// Stall:
//   A result waits in the output register until taken. The next update can
//   be accepted meanwhile, and its result waits for the register to free.
// ----------------------------------------------------------------------------
`default_nettype none

module peak_hold_level_meter
   import phlm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // bits: deviation_raw[15:0], strength_level[23:16], snr_level[31:24]
   input  wire logic [31:0]           req_tdata,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // bits: deviation_khz[13:0], lit_segments[18:14], peak_segment[23:19],
   //       snr_bar_length[30:24], strength_bar_length[37:31], zero[39:38]
   output logic [39:0]                rsp_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   // sequencer states
   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_KHZ_MUL = 4'd1;
   localparam logic [3:0] ST_Q_MUL   = 4'd2;
   localparam logic [3:0] ST_Q_DIV   = 4'd3;
   localparam logic [3:0] ST_SQ_MUL  = 4'd4;
   localparam logic [3:0] ST_LEN_MUL = 4'd5;
   localparam logic [3:0] ST_LEN_RCP = 4'd6;
   localparam logic [3:0] ST_LEN_SAT = 4'd7;
   localparam logic [3:0] ST_OUT     = 4'd8;

   // configuration registers
   logic [TICK_W-1:0] hold_ticks_ff, hold_ticks_in;
   logic [BAR_W-1:0]  bar_max_ff, bar_max_in;
   logic [FS_W-1:0]   snr_fs_ff, snr_fs_in;
   logic [FS_W-1:0]   str_fs_ff, str_fs_in;

   // sequencer and datapath registers
   logic [3:0]         state_ff, state_in;
   logic               chan_ff, chan_in;     // 0: SNR bar, 1: strength bar
   logic               div_go_ff, div_go_in;
   logic [DEV_W-1:0]   dev_ff, dev_in;
   logic [LEVEL_W-1:0] str_ff, str_in;
   logic [LEVEL_W-1:0] snr_ff, snr_in;
   logic [KHZ_W-1:0]   khz_ff, khz_in;
   logic [Q_W-1:0]     q_ff, q_in;
   logic [MUL_A_W-1:0] prod_ff, prod_in;
   logic [BAR_W-1:0]   snr_len_ff, snr_len_in;
   logic [BAR_W-1:0]   str_len_ff, str_len_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [39:0]        rsp_data_ff, rsp_data_in;

   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] mul_p;
   logic               div_done;
   logic [DIV_N_W-1:0] quotient;
   logic               peak_update;
   peak_status_type    peak_status;

   logic               req_accept;
   logic               rsp_free;
   logic [LEVEL_W-1:0] level;
   logic [FS_W-1:0]    fs_eff;
   logic               full_bar;
   logic [BAR_W-1:0]   len_raw;
   logic [BAR_W-1:0]   len_min;
   logic [BAR_W-1:0]   len_final;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // configuration writes
   always_comb begin
      hold_ticks_in = hold_ticks_ff;
      bar_max_in    = bar_max_ff;
      snr_fs_in     = snr_fs_ff;
      str_fs_in     = str_fs_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_HOLD_TICKS:  hold_ticks_in = csr_data;
            CSR_BAR_MAX:     bar_max_in    = csr_data[BAR_W-1:0];
            CSR_SNR_FS:      snr_fs_in     = csr_data;
            CSR_STRENGTH_FS: str_fs_in     = csr_data;
            default:         hold_ticks_in = hold_ticks_ff;
         endcase
      end
   end

   // bar channel selection; a full scale of zero acts as one
   assign level  = chan_ff ? str_ff : snr_ff;
   assign fs_eff = chan_ff ? ((str_fs_ff == '0) ? FS_W'(1) : str_fs_ff)
                           : ((snr_fs_ff == '0) ? FS_W'(1) : snr_fs_ff);
   // at or above full scale the ratio is >= 1000 and the bar saturates
   assign full_bar = (level >= fs_eff);

   // minimum of two for a nonzero reading, then saturate at the bar maximum
   assign len_raw   = prod_ff[BAR_W-1:0];
   assign len_min   = ((len_raw < BAR_MIN_LEN) && (level != '0)) ? BAR_MIN_LEN : len_raw;
   assign len_final = (full_bar || (len_min > bar_max_ff)) ? bar_max_ff : len_min;

   // shared multiplier operands
   always_comb begin
      unique case (state_ff)
         ST_KHZ_MUL: begin
            mul_a = MUL_A_W'(dev_ff);
            mul_b = KHZ_RECIP;
         end
         ST_Q_MUL: begin
            mul_a = MUL_A_W'(level);
            mul_b = RATIO_MULT;
         end
         ST_SQ_MUL: begin
            mul_a = MUL_A_W'(q_ff);
            mul_b = MUL_B_W'(q_ff);
         end
         ST_LEN_MUL: begin
            mul_a = prod_ff;
            mul_b = MUL_B_W'(bar_max_ff);
         end
         ST_LEN_RCP: begin
            mul_a = prod_ff;
            mul_b = LEN_RECIP;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // peak tracker takes the new kHz value once, at the first bar step
   assign peak_update = (state_ff == ST_Q_MUL) && !chan_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      chan_in      = chan_ff;
      div_go_in    = 1'b0;
      dev_in       = dev_ff;
      str_in       = str_ff;
      snr_in       = snr_ff;
      khz_in       = khz_ff;
      q_in         = q_ff;
      prod_in      = prod_ff;
      snr_len_in   = snr_len_ff;
      str_len_in   = str_len_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               dev_in   = req_tdata[15:0];
               str_in   = req_tdata[23:16];
               snr_in   = req_tdata[31:24];
               chan_in  = 1'b0;
               state_in = ST_KHZ_MUL;
            end
         end
         ST_KHZ_MUL: begin
            khz_in   = mul_p[KHZ_SHIFT +: KHZ_W];
            state_in = ST_Q_MUL;
         end
         ST_Q_MUL: begin
            prod_in   = mul_p[MUL_A_W-1:0];
            div_go_in = 1'b1;
            state_in  = ST_Q_DIV;
         end
         ST_Q_DIV: begin
            if (div_done) begin
               q_in     = quotient[Q_W-1:0];
               state_in = ST_SQ_MUL;
            end
         end
         ST_SQ_MUL: begin
            prod_in  = mul_p[MUL_A_W-1:0];
            state_in = ST_LEN_MUL;
         end
         ST_LEN_MUL: begin
            prod_in  = mul_p[MUL_A_W-1:0];
            state_in = ST_LEN_RCP;
         end
         // divide by one million through the reciprocal
         ST_LEN_RCP: begin
            prod_in  = MUL_A_W'(mul_p[LEN_SHIFT +: BAR_W]);
            state_in = ST_LEN_SAT;
         end
         ST_LEN_SAT: begin
            if (chan_ff) begin
               str_len_in = len_final;
               state_in   = ST_OUT;
            end else begin
               snr_len_in = len_final;
               chan_in    = 1'b1;
               state_in   = ST_Q_MUL;
            end
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_data_in  = {2'b00, str_len_ff, snr_len_ff, peak_status.peak,
                               peak_status.lit, khz_ff};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff <= HOLD_TICKS_RST;
         bar_max_ff    <= BAR_MAX_RST;
         snr_fs_ff     <= SNR_FS_RST;
         str_fs_ff     <= STRENGTH_FS_RST;
         state_ff      <= ST_IDLE;
         chan_ff       <= 1'b0;
         div_go_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_ticks_ff <= hold_ticks_in;
         bar_max_ff    <= bar_max_in;
         snr_fs_ff     <= snr_fs_in;
         str_fs_ff     <= str_fs_in;
         state_ff      <= state_in;
         chan_ff       <= chan_in;
         div_go_ff     <= div_go_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      dev_ff      <= dev_in;
      str_ff      <= str_in;
      snr_ff      <= snr_in;
      khz_ff      <= khz_in;
      q_ff        <= q_in;
      prod_ff     <= prod_in;
      snr_len_ff  <= snr_len_in;
      str_len_ff  <= str_len_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   phlm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go_ff),
      .dividend (prod_ff[DIV_N_W-1:0]),
      .divisor  (fs_eff),
      .done     (div_done),
      .quotient (quotient)
   );

   phlm_peak u_peak (
      .clock      (clock),
      .reset      (reset),
      .update     (peak_update),
      .khz        (khz_ff),
      .hold_ticks (hold_ticks_ff),
      .status     (peak_status)
   );

   // an accepted item always starts the sequence
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_KHZ_MUL))
      else $error("accepted item did not start the sequence");

   // divider completes only while the sequencer waits for it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_Q_DIV))
      else $error("divider finished outside a divide step");

   // a new result appears only from the output step
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !$past(rsp_tvalid && !rsp_tready) && !$past(reset))
         |-> $past(state_ff == ST_OUT))
      else $error("result presented without passing the output step");

   // divider start is issued only right after a multiply step
   a_go_after_mul: assert property (@(posedge clock) disable iff (reset)
      div_go_ff |-> (state_ff == ST_Q_DIV))
      else $error("divider started outside a divide step");

endmodule

`default_nettype wire
